/* rtl/assert_macros.svh */
// Assertion macros shared by the route table modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define RT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies another one in the following cycle.
`define RT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/aodv_rt_pkg.sv */
package aodv_rt_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] OP_RREQ   = 2'd0;
  localparam logic [1:0] OP_RREP   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_DEACT  = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] route_addr;
    logic [31:0] sender_addr;
    logic [31:0] seq_num;
    logic [7:0]  hop_count;
    logic [31:0] rreq_id;
  } item_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] next_hop;
    logic [31:0] seq;
    logic [7:0]  hops;
    logic [31:0] rreq_id;
    logic        active;
  } entry_t;

  typedef struct packed {
    logic        found;
    logic        updated;
    logic        table_full;
    logic [31:0] next_hop;
    logic [31:0] seq_out;
    logic [7:0]  hops_out;
    logic [31:0] rreq_id_out;
    logic        active_out;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/aodv_rt_if.sv */
interface aodv_rt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] route_addr;
  logic [31:0] sender_addr;
  logic [31:0] seq_num;
  logic [7:0]  hop_count;
  logic [31:0] rreq_id;

  modport source (
    output valid, operation, route_addr, sender_addr, seq_num, hop_count, rreq_id,
    input  ready
  );
  modport sink (
    input  valid, operation, route_addr, sender_addr, seq_num, hop_count, rreq_id,
    output ready
  );
endinterface

interface aodv_rt_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic        updated;
  logic        table_full;
  logic [31:0] next_hop;
  logic [31:0] seq_out;
  logic [7:0]  hops_out;
  logic [31:0] rreq_id_out;
  logic        active_out;

  modport source (
    output valid, found, updated, table_full, next_hop, seq_out, hops_out,
           rreq_id_out, active_out,
    input  ready
  );
  modport sink (
    input  valid, found, updated, table_full, next_hop, seq_out, hops_out,
           rreq_id_out, active_out,
    output ready
  );
endinterface

/* rtl/aodv_route_table_engine.sv */
// Channel | Direction | Transaction
// req_i   | in        | operation, route address, sender, sequence, hop count, request id
// rsp_o   | out       | found, updated, table full and the route as it stands afterward
//
// A search reads the filled entries in order, one RAM read per cycle, and ends at the first
// hit or after the last filled entry; an empty table ends it without a read.
// After the search a decide step commits the result into the output register once it is free.
// Reset clears the fill count, search state and output valid, not the RAM; entries past the fill count are never read.
// A request is accepted while the previous result waits; a stalled output holds the commit.
module aodv_route_table_engine (
  input  logic  clk_i,
  input  logic  rst_ni,
  aodv_rt_req_if.sink   req_i,
  aodv_rt_rsp_if.source rsp_o
);
  import aodv_rt_pkg::*;

  item_t      item;
  ctrl_cmd_t  cmd;
  dp_stat_t   stat;
  rsp_t       rsp;
  logic       in_ready;
  logic       out_valid;

  assign item.operation   = req_i.operation;
  assign item.route_addr  = req_i.route_addr;
  assign item.sender_addr = req_i.sender_addr;
  assign item.seq_num     = req_i.seq_num;
  assign item.hop_count   = req_i.hop_count;
  assign item.rreq_id     = req_i.rreq_id;
  assign req_i.ready      = in_ready;

  aodv_rt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  aodv_rt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .out_o       (rsp)
  );

  assign rsp_o.valid       = out_valid;
  assign rsp_o.found       = rsp.found;
  assign rsp_o.updated     = rsp.updated;
  assign rsp_o.table_full  = rsp.table_full;
  assign rsp_o.next_hop    = rsp.next_hop;
  assign rsp_o.seq_out     = rsp.seq_out;
  assign rsp_o.hops_out    = rsp.hops_out;
  assign rsp_o.rreq_id_out = rsp.rreq_id_out;
  assign rsp_o.active_out  = rsp.active_out;

endmodule

/* rtl/aodv_rt_ram.sv */
module aodv_rt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/aodv_rt_ctrl.sv */
`include "assert_macros.svh"

module aodv_rt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  aodv_rt_pkg::dp_stat_t  stat_i,
  output aodv_rt_pkg::ctrl_cmd_t cmd_o
);
  import aodv_rt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `RT_ASSERT_NEXT(a_accept_starts_search, in_valid_i && in_ready_o, state_q == S_SEARCH,
                  "accepted transaction did not start a search")
  `RT_ASSERT(a_commit_needs_free_out, !cmd_o.commit || stat_i.out_free,
             "result committed while the output register was occupied")

endmodule

/* rtl/aodv_rt_dp.sv */
`include "assert_macros.svh"

module aodv_rt_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  aodv_rt_pkg::item_t     item_i,
  input  aodv_rt_pkg::ctrl_cmd_t cmd_i,
  output aodv_rt_pkg::dp_stat_t  stat_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output aodv_rt_pkg::rsp_t      out_o
);
  import aodv_rt_pkg::*;

  item_t            item_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_idx_q;
  logic             found_q, found_d;
  logic [IDX_W-1:0] slot_q;
  entry_t           ent_q;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q;

  logic             issue;
  logic             hit;
  entry_t           rdata;
  logic [$bits(entry_t)-1:0] rdata_raw;

  logic [31:0]      cur_seq;
  logic [7:0]       cur_hops;
  logic             cur_act;
  logic             upd_op;
  logic             go;
  logic             need_new;
  logic             full;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           new_ent;
  rsp_t             rsp;

  assign issue = cmd_i.scan && (scan_q < cnt_q);
  assign rdata = entry_t'(rdata_raw);
  assign hit   = pend_q && (rdata.key == item_q.route_addr);

  assign stat_o.scan_done = hit || (!pend_q && (scan_q == cnt_q));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    scan_d  = scan_q;
    pend_d  = pend_q;
    found_d = found_q;
    if (cmd_i.load) begin
      scan_d  = '0;
      pend_d  = 1'b0;
      found_d = 1'b0;
    end else if (cmd_i.scan) begin
      pend_d = issue;
      if (issue) begin
        scan_d = scan_q + CNT_W'(1);
      end
      if (hit) begin
        found_d = 1'b1;
      end
    end
  end

  always_comb begin
    cur_seq  = found_q ? ent_q.seq : 32'd0;
    cur_hops = found_q ? ent_q.hops : 8'd0;
    cur_act  = found_q && ent_q.active;
    upd_op   = (item_q.operation == OP_RREQ) || (item_q.operation == OP_RREP);
    go       = (item_q.seq_num > cur_seq) || (cur_hops > item_q.hop_count) ||
               ((item_q.operation == OP_RREP) && !cur_act);
    need_new = upd_op && go && !found_q;
    full     = need_new && (cnt_q == CNT_W'(TABLE_ENTRIES));
    waddr    = found_q ? slot_q : cnt_q[IDX_W-1:0];
    new_ent  = ent_q;
    we       = 1'b0;
    if (upd_op && go && !full) begin
      we               = 1'b1;
      new_ent.key      = item_q.route_addr;
      new_ent.next_hop = item_q.sender_addr;
      new_ent.seq      = item_q.seq_num;
      new_ent.hops     = item_q.hop_count;
      new_ent.active   = 1'b1;
      if (item_q.operation == OP_RREQ) begin
        new_ent.rreq_id = item_q.rreq_id;
      end else if (!found_q) begin
        new_ent.rreq_id = 32'd0;
      end
    end else if ((item_q.operation == OP_DEACT) && found_q) begin
      we             = 1'b1;
      new_ent.active = 1'b0;
    end

    rsp            = '0;
    rsp.found      = found_q;
    rsp.updated    = we;
    rsp.table_full = full;
    if (found_q || we) begin
      rsp.next_hop    = new_ent.next_hop;
      rsp.seq_out     = new_ent.seq;
      rsp.hops_out    = new_ent.hops;
      rsp.rreq_id_out = new_ent.rreq_id;
      rsp.active_out  = new_ent.active;
    end

    cnt_d = cnt_q;
    if (cmd_i.commit && need_new && !full) begin
      cnt_d = cnt_q + CNT_W'(1);
    end

    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  aodv_rt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && we),
    .waddr_i (waddr),
    .wdata_i (new_ent),
    .re_i    (issue),
    .raddr_i (scan_q[IDX_W-1:0]),
    .rdata_o (rdata_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (issue) begin
      pend_idx_q <= scan_q[IDX_W-1:0];
    end
    if (cmd_i.scan && hit) begin
      slot_q <= pend_idx_q;
      ent_q  <= rdata;
    end
    if (cmd_i.commit) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `RT_ASSERT(a_fill_in_range, cnt_q <= CNT_W'(TABLE_ENTRIES),
             "fill count exceeds the table size")
  `RT_ASSERT(a_scan_in_fill, scan_q <= cnt_q,
             "search pointer passed the filled part of the table")
  `RT_ASSERT_NEXT(a_commit_shows_result, cmd_i.commit, out_valid_q,
                  "committed result did not reach the output register")

endmodule

/* tb/testbench.sv */
module testbench;
  import aodv_rt_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 830;
  localparam int unsigned POOL_LIMIT     = 80;
  localparam int unsigned STALL_LIMIT    = 3000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned HOLD_AT_RESULT = 120;
  localparam int unsigned DRAIN_CYCLES   = 80;

  logic clk_i = 1'b0;
  logic rst_ni;

  aodv_rt_req_if req_ch ();
  aodv_rt_rsp_if rsp_ch ();

  aodv_route_table_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the route table.
  logic   shadow_valid [TABLE_ENTRIES];
  entry_t shadow_entry [TABLE_ENTRIES];

  item_t       pending_items [$];
  rsp_t        expected_routes [$];
  logic [31:0] addr_pool [$];
  item_t       drive_item;
  int unsigned total_items;
  int unsigned items_issued;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned stall_cycles;
  int unsigned hold_left;
  bit          hold_done;
  bit          req_taken;

  function automatic rsp_t route_step(item_t it);
    int          slot;
    bit          hit;
    bit          go;
    bit          full;
    bit          wrote;
    logic [31:0] cur_seq;
    logic [7:0]  cur_hops;
    logic        cur_act;
    rsp_t        r;
    slot = -1;
    full = 1'b0;
    wrote = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot < 0 && shadow_valid[i] && shadow_entry[i].key == it.route_addr) begin
        slot = i;
      end
    end
    hit = (slot >= 0);
    if (it.operation == OP_RREQ || it.operation == OP_RREP) begin
      cur_seq  = hit ? shadow_entry[slot].seq : 32'd0;
      cur_hops = hit ? shadow_entry[slot].hops : 8'd0;
      cur_act  = hit ? shadow_entry[slot].active : 1'b0;
      go = (it.seq_num > cur_seq) || (cur_hops > it.hop_count);
      if (it.operation == OP_RREP && !cur_act) begin
        go = 1'b1;
      end
      if (go) begin
        if (!hit) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot < 0 && !shadow_valid[i]) begin
              slot = i;
            end
          end
          if (slot < 0) begin
            full = 1'b1;
          end else begin
            shadow_valid[slot] = 1'b1;
            shadow_entry[slot].key = it.route_addr;
            shadow_entry[slot].rreq_id = 32'd0;
          end
        end
        if (slot >= 0) begin
          shadow_entry[slot].next_hop = it.sender_addr;
          shadow_entry[slot].active = 1'b1;
          shadow_entry[slot].seq = it.seq_num;
          shadow_entry[slot].hops = it.hop_count;
          if (it.operation == OP_RREQ) begin
            shadow_entry[slot].rreq_id = it.rreq_id;
          end
          wrote = 1'b1;
        end
      end
    end else if (it.operation == OP_DEACT && hit) begin
      shadow_entry[slot].active = 1'b0;
      wrote = 1'b1;
    end
    r = '0;
    r.found = hit;
    r.updated = wrote;
    r.table_full = full;
    if (slot >= 0) begin
      r.next_hop = shadow_entry[slot].next_hop;
      r.seq_out = shadow_entry[slot].seq;
      r.hops_out = shadow_entry[slot].hops;
      r.rreq_id_out = shadow_entry[slot].rreq_id;
      r.active_out = shadow_entry[slot].active;
    end
    return r;
  endfunction

  // Mostly small values so that the sequence and hop comparisons go both ways.
  function automatic logic [31:0] skewed_value(logic [31:0] top);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return $urandom_range(0, 15) & top;
    end else if (roll < 85) begin
      return $urandom() & top;
    end
    return ($urandom_range(0, 1) != 0) ? top : 32'd0;
  endfunction

  function automatic item_t random_route_item();
    item_t       it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      it.operation = OP_RREQ;
    end else if (roll < 65) begin
      it.operation = OP_RREP;
    end else if (roll < 85) begin
      it.operation = OP_LOOKUP;
    end else begin
      it.operation = OP_DEACT;
    end
    if (addr_pool.size() != 0 && $urandom_range(0, 99) < 80) begin
      it.route_addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    end else begin
      it.route_addr = $urandom();
      if (addr_pool.size() < POOL_LIMIT) begin
        addr_pool.push_back(it.route_addr);
      end
    end
    it.sender_addr = $urandom();
    it.seq_num = skewed_value(32'hFFFF_FFFF);
    it.hop_count = 8'(skewed_value(32'h0000_00FF));
    it.rreq_id = $urandom();
    return it;
  endfunction

  function automatic item_t route_item(logic [1:0] op, logic [31:0] addr, logic [31:0] sender,
                                       logic [31:0] seq, logic [7:0] hops, logic [31:0] rid);
    item_t it;
    it.operation = op;
    it.route_addr = addr;
    it.sender_addr = sender;
    it.seq_num = seq;
    it.hop_count = hops;
    it.rreq_id = rid;
    return it;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  function automatic int unsigned sender_idle_pct();
    if (items_issued < total_items / 3) begin
      return 27;
    end else if (items_issued < 2 * total_items / 3) begin
      return 61;
    end
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (items_issued < total_items / 3) begin
      return 61;
    end else if (items_issued < 2 * total_items / 3) begin
      return 27;
    end
    return 0;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_ch.valid || req_taken) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          drive_item = pending_items.pop_front();
          items_issued++;
          req_ch.valid <= 1'b1;
          req_ch.operation <= drive_item.operation;
          req_ch.route_addr <= drive_item.route_addr;
          req_ch.sender_addr <= drive_item.sender_addr;
          req_ch.seq_num <= drive_item.seq_num;
          req_ch.hop_count <= drive_item.hop_count;
          req_ch.rreq_id <= drive_item.rreq_id;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    item_t got_item;
    rsp_t  want;
    if (rst_ni) begin
      req_taken = req_ch.valid && req_ch.ready;
      if (req_taken) begin
        got_item = route_item(req_ch.operation, req_ch.route_addr, req_ch.sender_addr,
                              req_ch.seq_num, req_ch.hop_count, req_ch.rreq_id);
        expected_routes.push_back(route_step(got_item));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (expected_routes.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected transaction on the result channel", $time);
        end else begin
          want = expected_routes.pop_front();
          check_field("found", 32'(want.found), 32'(rsp_ch.found));
          check_field("updated", 32'(want.updated), 32'(rsp_ch.updated));
          check_field("table_full", 32'(want.table_full), 32'(rsp_ch.table_full));
          check_field("next_hop", want.next_hop, rsp_ch.next_hop);
          check_field("seq_out", want.seq_out, rsp_ch.seq_out);
          check_field("hops_out", 32'(want.hops_out), 32'(rsp_ch.hops_out));
          check_field("rreq_id_out", want.rreq_id_out, rsp_ch.rreq_id_out);
          check_field("active_out", 32'(want.active_out), 32'(rsp_ch.active_out));
        end
      end
      if (req_taken || (rsp_ch.valid && rsp_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_LOOKUP;
    req_ch.route_addr = '0;
    req_ch.sender_addr = '0;
    req_ch.seq_num = '0;
    req_ch.hop_count = '0;
    req_ch.rreq_id = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_entry[i] = '0;
    end

    // Missing routes, each comparison outcome, inactive reply refresh and extremes.
    pending_items.push_back(route_item(OP_LOOKUP, 32'd5, 32'd0, 32'd0, 8'd0, 32'd0));
    pending_items.push_back(route_item(OP_DEACT, 32'd5, 32'd0, 32'd0, 8'd0, 32'd0));
    pending_items.push_back(route_item(OP_RREQ, 32'd5, 32'd11, 32'd0, 8'd3, 32'd7));
    pending_items.push_back(route_item(OP_RREQ, 32'd5, 32'd12, 32'd10, 8'd3, 32'd8));
    pending_items.push_back(route_item(OP_RREQ, 32'd5, 32'd13, 32'd10, 8'd3, 32'd9));
    pending_items.push_back(route_item(OP_RREQ, 32'd5, 32'd14, 32'd10, 8'd2, 32'd10));
    pending_items.push_back(route_item(OP_RREQ, 32'd5, 32'd15, 32'd9, 8'd5, 32'd11));
    pending_items.push_back(route_item(OP_RREP, 32'd5, 32'd16, 32'd9, 8'd9, 32'd12));
    pending_items.push_back(route_item(OP_DEACT, 32'd5, 32'd0, 32'd0, 8'd0, 32'd0));
    pending_items.push_back(route_item(OP_RREP, 32'd5, 32'd17, 32'd0, 8'd255, 32'd13));
    pending_items.push_back(route_item(OP_LOOKUP, 32'd5, 32'd0, 32'd0, 8'd0, 32'd0));
    pending_items.push_back(route_item(OP_RREP, 32'd0, 32'd0, 32'd0, 8'd0, 32'hFFFF_FFFF));
    pending_items.push_back(route_item(OP_RREQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       8'd255, 32'hFFFF_FFFF));
    pending_items.push_back(route_item(OP_RREQ, 32'hFFFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFE,
                                       8'd0, 32'h5A5A_A5A5));
    pending_items.push_back(route_item(OP_RREQ, 32'd0, 32'd21, 32'd1, 8'd0, 32'd0));
    pending_items.push_back(route_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'd0, 32'd0));
    pending_items.push_back(route_item(OP_DEACT, 32'd0, 32'd0, 32'd0, 8'd0, 32'd0));
    pending_items.push_back(route_item(OP_DEACT, 32'd0, 32'd0, 32'd0, 8'd0, 32'd0));
    pending_items.push_back(route_item(OP_RREP, 32'd0, 32'd22, 32'd0, 8'd0, 32'd23));
    pending_items.push_back(route_item(OP_RREQ, 32'd77, 32'd24, 32'd0, 8'd0, 32'd25));
    addr_pool.push_back(32'd5);
    addr_pool.push_back(32'd0);
    addr_pool.push_back(32'hFFFF_FFFF);
    repeat (RANDOM_ITEMS) begin
      pending_items.push_back(random_route_item());
    end
    total_items = pending_items.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || req_ch.valid || expected_routes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
